/* rtl/lcfp_pkg.sv */
// lcfp_pkg: shared types and constants for the LED command frame parser.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps

package lcfp_pkg;

    localparam int FRAME_LENGTH = 7;
    localparam int POS_W        = 3;
    localparam int BYTE_W       = 8;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 2;

    // frame byte positions
    localparam logic [POS_W-1:0] POS_HDR0    = 3'd0;
    localparam logic [POS_W-1:0] POS_HDR1    = 3'd1;
    localparam logic [POS_W-1:0] POS_LENGTH  = 3'd2;
    localparam logic [POS_W-1:0] POS_COMMAND = 3'd3;
    localparam logic [POS_W-1:0] POS_SWITCH  = 3'd4;
    localparam logic [POS_W-1:0] POS_LED     = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_LED      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CHECKSUM = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OTHER    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNUSED   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HEADER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COMMAND   = 2'd2;

    localparam logic [BYTE_W-1:0] RST_FIRST_HEADER  = 8'h55;
    localparam logic [BYTE_W-1:0] RST_SECOND_HEADER = 8'hAA;
    localparam logic [BYTE_W-1:0] RST_LED_COMMAND   = 8'h06;

    // frame queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    // classified frame as handed from front to back
    typedef struct packed {
        logic              sum_ok;
        logic              cmd_match;
        logic              switch_on;
        logic [BYTE_W-1:0] led_number;
    } frame_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] first_header;
        logic [BYTE_W-1:0] second_header;
        logic [BYTE_W-1:0] led_command_code;
    } cfg_regs_t;

endpackage

/* rtl/lcfp_front.sv */
// lcfp_front: byte position tracking, header match, running XOR and frame
// classification. Depends on lcfp_pkg.
`timescale 1ns / 1ps

module lcfp_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         byte_valid,
    input  logic [lcfp_pkg::BYTE_W-1:0]  byte_data,
    input  lcfp_pkg::cfg_regs_t          cfg,
    output logic                         rec_valid,
    output lcfp_pkg::frame_rec_t         rec
);

    logic [lcfp_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [lcfp_pkg::BYTE_W-1:0] xor_reg, xor_next;
    logic [lcfp_pkg::BYTE_W-1:0] cmd_reg, sw_reg, led_reg;

    always_comb
    begin
        pos_next  = pos_reg;
        xor_next  = xor_reg;
        rec_valid = 1'b0;
        if (byte_valid)
        begin
            unique case (pos_reg)
                lcfp_pkg::POS_HDR0:
                begin
                    if (byte_data == cfg.first_header)
                    begin
                        xor_next = byte_data;
                        pos_next = lcfp_pkg::POS_HDR1;
                    end
                    else
                    begin
                        pos_next = lcfp_pkg::POS_HDR0;
                    end
                end
                lcfp_pkg::POS_HDR1:
                begin
                    if (byte_data == cfg.second_header)
                    begin
                        xor_next = xor_reg ^ byte_data;
                        pos_next = lcfp_pkg::POS_LENGTH;
                    end
                    else
                    begin
                        pos_next = lcfp_pkg::POS_HDR0;
                    end
                end
                lcfp_pkg::POS_LENGTH, lcfp_pkg::POS_COMMAND,
                lcfp_pkg::POS_SWITCH, lcfp_pkg::POS_LED:
                begin
                    xor_next = xor_reg ^ byte_data;
                    pos_next = pos_reg + 3'd1;
                end
                default:
                begin
                    // checksum byte
                    rec_valid = 1'b1;
                    xor_next  = '0;
                    pos_next  = lcfp_pkg::POS_HDR0;
                end
            endcase
        end
    end

    always_comb
    begin
        rec.sum_ok     = (xor_reg == byte_data);
        rec.cmd_match  = (cmd_reg == cfg.led_command_code);
        rec.switch_on  = (sw_reg != '0);
        rec.led_number = led_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= lcfp_pkg::POS_HDR0;
            xor_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            xor_reg <= xor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && pos_reg == lcfp_pkg::POS_COMMAND)
        begin
            cmd_reg <= byte_data;
        end
        if (byte_valid && pos_reg == lcfp_pkg::POS_SWITCH)
        begin
            sw_reg <= byte_data;
        end
        if (byte_valid && pos_reg == lcfp_pkg::POS_LED)
        begin
            led_reg <= byte_data;
        end
    end

endmodule

/* rtl/lcfp_queue.sv */
// lcfp_queue: short register queue of classified frames between front and back.
// Depends on lcfp_pkg.
`timescale 1ns / 1ps

module lcfp_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  lcfp_pkg::frame_rec_t  wr_data,
    input  logic                  rd_en,
    output lcfp_pkg::frame_rec_t  rd_data,
    output lcfp_pkg::queue_stat_t stat
);

    lcfp_pkg::frame_rec_t entry_reg [lcfp_pkg::QUEUE_DEPTH];
    logic [lcfp_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [lcfp_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [lcfp_pkg::QUEUE_CW-1:0] count_reg, count_next;
    logic do_wr, do_rd;

    assign stat.full  = (count_reg == lcfp_pkg::QUEUE_CW'(lcfp_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/lcfp_back.sv */
// lcfp_back: turns classified frames into result beats and holds the output
// register toward the consumer. Depends on lcfp_pkg.
`timescale 1ns / 1ps

module lcfp_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lcfp_pkg::queue_stat_t               q_stat,
    input  lcfp_pkg::frame_rec_t                q_data,
    output logic                                q_rd,
    input  logic                                out_pop,
    output logic                                out_valid,
    output logic [lcfp_pkg::STATUS_W-1:0]       out_status,
    output logic [lcfp_pkg::BYTE_W-1:0]         out_led,
    output logic                                out_on
);

    logic                              valid_reg, valid_next;
    logic [lcfp_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [lcfp_pkg::BYTE_W-1:0]       led_reg, led_next;
    logic                              on_reg, on_next;

    // refill the output register when it is empty or being drained
    assign q_rd = !q_stat.empty && (!valid_reg || out_pop);

    always_comb
    begin
        status_next = status_reg;
        led_next    = led_reg;
        on_next     = on_reg;
        valid_next  = valid_reg && !out_pop;
        if (q_rd)
        begin
            valid_next = 1'b1;
            priority if (!q_data.sum_ok)
            begin
                status_next = lcfp_pkg::STATUS_CHECKSUM;
                led_next    = '0;
                on_next     = 1'b0;
            end
            else if (!q_data.cmd_match)
            begin
                status_next = lcfp_pkg::STATUS_OTHER;
                led_next    = '0;
                on_next     = 1'b0;
            end
            else
            begin
                status_next = lcfp_pkg::STATUS_LED;
                led_next    = q_data.led_number;
                on_next     = q_data.switch_on;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        led_reg    <= led_next;
        on_reg     <= on_next;
    end

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_led    = led_reg;
    assign out_on     = on_reg;

endmodule

/* rtl/led_command_frame_parser.sv */
// LED command frame parser top level: config registers, front, queue, back.
// Takes one byte per cycle; input stalls only while the two-entry frame queue is full.
// A frame result is queued on the edge that accepts its checksum byte and then loaded
// into the output register driving the result ports once that register is free.
// Reset clears byte position, running XOR, queue and output valid; config
// registers return to 0x55, 0xAA and 0x06. Depends on lcfp_pkg.
`timescale 1ns / 1ps

module led_command_frame_parser
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [lcfp_pkg::BYTE_W-1:0]         rx_byte,
    output logic                                empty,
    input  logic                                pop,
    output logic [lcfp_pkg::STATUS_W-1:0]       frame_status,
    output logic [lcfp_pkg::BYTE_W-1:0]         led_index,
    output logic                                led_turn_on,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lcfp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lcfp_pkg::BYTE_W-1:0]         cfg_data
);

    lcfp_pkg::cfg_regs_t   cfg_reg;
    lcfp_pkg::frame_rec_t  front_rec, q_rec;
    lcfp_pkg::queue_stat_t q_stat;
    logic                  byte_acc, front_rec_valid, q_rd, out_valid;

    assign cfg_ready = 1'b1;
    assign full      = q_stat.full;
    assign byte_acc  = push && !full;
    assign empty     = !out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_header     <= lcfp_pkg::RST_FIRST_HEADER;
            cfg_reg.second_header    <= lcfp_pkg::RST_SECOND_HEADER;
            cfg_reg.led_command_code <= lcfp_pkg::RST_LED_COMMAND;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lcfp_pkg::CFG_FIRST_HEADER:  cfg_reg.first_header     <= cfg_data;
                lcfp_pkg::CFG_SECOND_HEADER: cfg_reg.second_header    <= cfg_data;
                lcfp_pkg::CFG_LED_COMMAND:   cfg_reg.led_command_code <= cfg_data;
                default:                     ; // unmapped index, write dropped
            endcase
        end
    end

    lcfp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_acc),
        .byte_data  (rx_byte),
        .cfg        (cfg_reg),
        .rec_valid  (front_rec_valid),
        .rec        (front_rec)
    );

    lcfp_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_rec_valid),
        .wr_data (front_rec),
        .rd_en   (q_rd),
        .rd_data (q_rec),
        .stat    (q_stat)
    );

    lcfp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .q_data     (q_rec),
        .q_rd       (q_rd),
        .out_pop    (pop),
        .out_valid  (out_valid),
        .out_status (frame_status),
        .out_led    (led_index),
        .out_on     (led_turn_on)
    );

`ifndef SYNTHESIS
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> frame_status != lcfp_pkg::STATUS_UNUSED)
        else $error("unused status code on result port");

    a_error_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_status != lcfp_pkg::STATUS_LED)
            |-> (led_index == '0 && !led_turn_on))
        else $error("error result carries LED fields");

    a_frame_queued: assert property (@(posedge clk) disable iff (!rst_n)
        front_rec_valid |=> !q_stat.empty)
        else $error("completed frame not held in queue");
`endif

endmodule
